// ===== rtl/tvbm_pkg.sv =====
// tvbm_pkg: register index codes and control structs for the tvb minmod face slope limiter
// no dependencies; compiled first
package tvbm_pkg;

  // configuration port
  localparam int CFG_INDEX_BITS = 3;

  localparam logic [CFG_INDEX_BITS-1:0] REG_LIMITER_ENABLE   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TVB_THRESHOLD    = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CHANGE_THRESHOLD = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_X_BASIS_SCALE    = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_Y_BASIS_SCALE    = 3'd4;

  // request control between the difference and jump stages
  typedef struct packed {
    logic valid;
    logic sat;
  } tvbm_ctl_t;

  // request control between the jump and coefficient stages
  typedef struct packed {
    logic valid;
    logic sat;
    logic lim;
  } tvbm_lim_ctl_t;

endpackage

// ===== rtl/tvbm_if.sv =====
// tvbm_cell_if and tvbm_result_if: valid/ready channels for cell requests and results
// no dependencies; payload width follows VALUE_BITS
interface tvbm_cell_if #(
  parameter int VALUE_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] cell_mean;
  logic signed [VALUE_BITS-1:0] left_mean;
  logic signed [VALUE_BITS-1:0] right_mean;
  logic signed [VALUE_BITS-1:0] bottom_mean;
  logic signed [VALUE_BITS-1:0] top_mean;
  logic        [3:0]            neighbour_mask;
  logic signed [VALUE_BITS-1:0] face_left;
  logic signed [VALUE_BITS-1:0] face_right;
  logic signed [VALUE_BITS-1:0] face_bottom;
  logic signed [VALUE_BITS-1:0] face_top;

  modport source (
    output valid, cell_mean, left_mean, right_mean, bottom_mean, top_mean,
           neighbour_mask, face_left, face_right, face_bottom, face_top,
    input  ready
  );

  modport sink (
    input  valid, cell_mean, left_mean, right_mean, bottom_mean, top_mean,
           neighbour_mask, face_left, face_right, face_bottom, face_top,
    output ready
  );
endinterface

interface tvbm_result_if #(
  parameter int VALUE_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic                         limited;
  logic signed [VALUE_BITS-1:0] x_slope_coeff;
  logic signed [VALUE_BITS-1:0] y_slope_coeff;
  logic                         saturated;

  modport source (
    output valid, limited, x_slope_coeff, y_slope_coeff, saturated,
    input  ready
  );

  modport sink (
    input  valid, limited, x_slope_coeff, y_slope_coeff, saturated,
    output ready
  );
endinterface

// ===== rtl/tvb_minmod_face_slope_limiter.sv =====
// tvb_minmod_face_slope_limiter: top level, configuration registers and the limiter pipeline
// depends on tvbm_pkg, tvbm_if, tvbm_diff, tvbm_jump and tvbm_coeff

// One cell request enters per clock unless a stalled result holds it back: one stage forms
// the saturated differences, three stages do the minmod, the change sum and the limit decision,
// and three more scale the half-sum slopes by the basis reciprocals through four half-width
// partial products per direction, round and clip. Every stage has its own valid bit and
// moves when the stage after it is free, so a stalled result holds only the stages behind it
// and bubbles still close up. There is no state besides the configuration registers and no
// clearing pass after reset. Registers are written through cfg_wr_en, cfg_index and
// cfg_data; write them only while no request is in flight.
module tvb_minmod_face_slope_limiter
  import tvbm_pkg::*;
#(
  parameter int VALUE_BITS    = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  tvbm_cell_if.sink                 cell_req,
  tvbm_result_if.source             result,
  input  logic                      cfg_wr_en,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [VALUE_BITS-1:0]     cfg_data
);

  localparam int W = VALUE_BITS;
  localparam logic signed [W-1:0] SCALE_ONE = {{(W-1){1'b0}}, 1'b1} << FRACTION_BITS;

  logic                limiter_enable;
  logic        [W-2:0] tvb_threshold;
  logic        [W-2:0] change_threshold;
  logic signed [W-1:0] x_basis_scale;
  logic signed [W-1:0] y_basis_scale;

  // register writes, unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      limiter_enable   <= 1'b1;
      tvb_threshold    <= '0;
      change_threshold <= '0;
      x_basis_scale    <= SCALE_ONE;
      y_basis_scale    <= SCALE_ONE;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_LIMITER_ENABLE:   limiter_enable   <= cfg_data[0];
        REG_TVB_THRESHOLD:    tvb_threshold    <= cfg_data[W-2:0];
        REG_CHANGE_THRESHOLD: change_threshold <= cfg_data[W-2:0];
        REG_X_BASIS_SCALE:    x_basis_scale    <= cfg_data;
        REG_Y_BASIS_SCALE:    y_basis_scale    <= cfg_data;
        default: ;
      endcase
    end
  end

  tvbm_ctl_t           diff_ctl;
  tvbm_lim_ctl_t       jump_ctl;
  logic                jump_ready;
  logic                coeff_ready;
  logic signed [W-1:0] nb_back [2];
  logic signed [W-1:0] nb_front [2];
  logic signed [W-1:0] jump_back [2];
  logic signed [W-1:0] jump_front [2];
  logic        [W-1:0] h_mag [2];
  logic                h_neg [2];

  // differences
  tvbm_diff #(
    .VALUE_BITS (VALUE_BITS)
  ) u_diff (
    .clk        (clk),
    .rst        (rst),
    .cell_req   (cell_req),
    .ctl        (diff_ctl),
    .out_ready  (jump_ready),
    .nb_back    (nb_back),
    .nb_front   (nb_front),
    .jump_back  (jump_back),
    .jump_front (jump_front)
  );

  // minmod and limit decision
  tvbm_jump #(
    .VALUE_BITS (VALUE_BITS)
  ) u_jump (
    .clk              (clk),
    .rst              (rst),
    .ctl              (diff_ctl),
    .in_ready         (jump_ready),
    .nb_back          (nb_back),
    .nb_front         (nb_front),
    .jump_back        (jump_back),
    .jump_front       (jump_front),
    .tvb_threshold    (tvb_threshold),
    .change_threshold (change_threshold),
    .lctl             (jump_ctl),
    .out_ready        (coeff_ready),
    .h_mag            (h_mag),
    .h_neg            (h_neg)
  );

  // slope coefficients
  tvbm_coeff #(
    .VALUE_BITS    (VALUE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_coeff (
    .clk      (clk),
    .rst      (rst),
    .lctl     (jump_ctl),
    .in_ready (coeff_ready),
    .h_mag    (h_mag),
    .h_neg    (h_neg),
    .x_scale  (x_basis_scale),
    .y_scale  (y_basis_scale),
    .enable   (limiter_enable),
    .result   (result)
  );

endmodule

// ===== rtl/tvbm_diff.sv =====
// tvbm_diff: first pipeline stage, saturated neighbour differences and face jumps
// depends on tvbm_pkg and tvbm_cell_if
module tvbm_diff
  import tvbm_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  tvbm_cell_if.sink                    cell_req,
  output tvbm_ctl_t                    ctl,
  input  logic                         out_ready,
  output logic signed [VALUE_BITS-1:0] nb_back [2],
  output logic signed [VALUE_BITS-1:0] nb_front [2],
  output logic signed [VALUE_BITS-1:0] jump_back [2],
  output logic signed [VALUE_BITS-1:0] jump_front [2]
);

  localparam int W = VALUE_BITS;
  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  // a - b clipped to the value range, clip flag on top
  function automatic logic [W:0] sat_sub(input logic signed [W-1:0] a,
                                         input logic signed [W-1:0] b);
    logic signed [W:0] d;
    d = {a[W-1], a} - {b[W-1], b};
    if (d[W] != d[W-1]) return {1'b1, (d[W] ? VMIN : VMAX)};
    return {1'b0, d[W-1:0]};
  endfunction

  logic [W:0] r_db [2];
  logic [W:0] r_df [2];
  logic [W:0] r_jb [2];
  logic [W:0] r_jf [2];
  logic       sat_any;
  logic       valid;
  logic       sat;

  // differences per direction, absent neighbours give zero
  always_comb begin
    r_db[0] = cell_req.neighbour_mask[0] ?
              sat_sub(cell_req.cell_mean, cell_req.left_mean) : '0;
    r_df[0] = cell_req.neighbour_mask[1] ?
              sat_sub(cell_req.right_mean, cell_req.cell_mean) : '0;
    r_db[1] = cell_req.neighbour_mask[2] ?
              sat_sub(cell_req.cell_mean, cell_req.bottom_mean) : '0;
    r_df[1] = cell_req.neighbour_mask[3] ?
              sat_sub(cell_req.top_mean, cell_req.cell_mean) : '0;
    r_jb[0] = sat_sub(cell_req.cell_mean, cell_req.face_left);
    r_jf[0] = sat_sub(cell_req.face_right, cell_req.cell_mean);
    r_jb[1] = sat_sub(cell_req.cell_mean, cell_req.face_bottom);
    r_jf[1] = sat_sub(cell_req.face_top, cell_req.cell_mean);
    sat_any = r_db[0][W] | r_df[0][W] | r_db[1][W] | r_df[1][W] |
              r_jb[0][W] | r_jf[0][W] | r_jb[1][W] | r_jf[1][W];
  end

  // stage holds while the next one is full and stalled
  assign cell_req.ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cell_req.ready) begin
      valid <= cell_req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cell_req.ready) begin
      sat <= sat_any;
      for (int d = 0; d < 2; d++) begin
        nb_back[d]    <= r_db[d][W-1:0];
        nb_front[d]   <= r_df[d][W-1:0];
        jump_back[d]  <= r_jb[d][W-1:0];
        jump_front[d] <= r_jf[d][W-1:0];
      end
    end
  end

  assign ctl.valid = valid;
  assign ctl.sat   = sat;

endmodule

// ===== rtl/tvbm_jump.sv =====
// tvbm_jump: three pipeline stages, tvb minmod of the jumps, change sum and limit decision
// depends on tvbm_pkg
module tvbm_jump
  import tvbm_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  tvbm_ctl_t                    ctl,
  output logic                         in_ready,
  input  logic signed [VALUE_BITS-1:0] nb_back [2],
  input  logic signed [VALUE_BITS-1:0] nb_front [2],
  input  logic signed [VALUE_BITS-1:0] jump_back [2],
  input  logic signed [VALUE_BITS-1:0] jump_front [2],
  input  logic        [VALUE_BITS-2:0] tvb_threshold,
  input  logic        [VALUE_BITS-2:0] change_threshold,
  output tvbm_lim_ctl_t                lctl,
  input  logic                         out_ready,
  output logic        [VALUE_BITS-1:0] h_mag [2],
  output logic                         h_neg [2]
);

  localparam int W = VALUE_BITS;

  function automatic logic [W-1:0] mag(input logic signed [W-1:0] a);
    logic [W-1:0] u;
    u = a;
    return a[W-1] ? (~u + 1'b1) : u;
  endfunction

  // small jumps pass, otherwise signs must agree (zero counts as negative)
  function automatic logic signed [W-1:0] minmod(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b,
                                                 input logic signed [W-1:0] c,
                                                 input logic [W-2:0] thr);
    logic [W-1:0] ma;
    logic [W-1:0] mb;
    logic [W-1:0] mc;
    logic [W-1:0] m;
    logic         na;
    logic         nb;
    logic         nc;
    ma = mag(a);
    mb = mag(b);
    mc = mag(c);
    na = a[W-1] || (a == '0);
    nb = b[W-1] || (b == '0);
    nc = c[W-1] || (c == '0);
    m = ma;
    if (mb < m) m = mb;
    if (mc < m) m = mc;
    if (ma < {1'b0, thr}) return a;
    if (na != nb || na != nc) return '0;
    return na ? (~m + 1'b1) : m;
  endfunction

  function automatic logic [W-1:0] abs_diff(input logic signed [W-1:0] x,
                                            input logic signed [W-1:0] y);
    logic signed [W:0] d;
    logic        [W:0] n;
    d = {x[W-1], x} - {y[W-1], y};
    n = -d;
    return d[W] ? n[W-1:0] : d[W-1:0];
  endfunction

  // floor of the exact half sum
  function automatic logic signed [W-1:0] half_sum(input logic signed [W-1:0] a,
                                                   input logic signed [W-1:0] b);
    logic signed [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    return s[W:1];
  endfunction

  logic                v2, v3, v4;
  logic                en2, en3, en4;
  logic                sat2, sat3, sat4, lim4;
  logic signed [W-1:0] jb2 [2];
  logic signed [W-1:0] jf2 [2];
  logic signed [W-1:0] raw_b2 [2];
  logic signed [W-1:0] raw_f2 [2];
  logic        [W-1:0] dev3 [4];
  logic signed [W-1:0] h3 [2];
  logic        [W+1:0] total;

  // per-stage enables, a bubble lets upstream move on
  assign en4      = !v4 || out_ready;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign in_ready = en2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en2) v2 <= ctl.valid;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  // minmod of back and front jumps against both neighbour differences
  always_ff @(posedge clk) begin
    if (en2) begin
      sat2 <= ctl.sat;
      for (int d = 0; d < 2; d++) begin
        jb2[d]    <= minmod(jump_back[d], nb_back[d], nb_front[d], tvb_threshold);
        jf2[d]    <= minmod(jump_front[d], nb_back[d], nb_front[d], tvb_threshold);
        raw_b2[d] <= jump_back[d];
        raw_f2[d] <= jump_front[d];
      end
    end
  end

  // absolute changes and half sums of the limited jumps
  always_ff @(posedge clk) begin
    if (en3) begin
      sat3 <= sat2;
      for (int d = 0; d < 2; d++) begin
        dev3[2*d]   <= abs_diff(jb2[d], raw_b2[d]);
        dev3[2*d+1] <= abs_diff(jf2[d], raw_f2[d]);
        h3[d]       <= half_sum(jb2[d], jf2[d]);
      end
    end
  end

  // a quarter of the sum above the threshold is the sum above four times it
  assign total = (W+2)'(dev3[0]) + (W+2)'(dev3[1]) + (W+2)'(dev3[2]) + (W+2)'(dev3[3]);

  always_ff @(posedge clk) begin
    if (en4) begin
      sat4 <= sat3;
      lim4 <= total > {1'b0, change_threshold, 2'b00};
      for (int d = 0; d < 2; d++) begin
        h_mag[d] <= mag(h3[d]);
        h_neg[d] <= h3[d][W-1];
      end
    end
  end

  assign lctl.valid = v4;
  assign lctl.sat   = sat4;
  assign lctl.lim   = lim4;

endmodule

// ===== rtl/tvbm_coeff.sv =====
// tvbm_coeff: three pipeline stages, basis scaling by partial products, rounding, clipping
// depends on tvbm_pkg and tvbm_result_if
module tvbm_coeff
  import tvbm_pkg::*;
#(
  parameter int VALUE_BITS    = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  tvbm_lim_ctl_t                lctl,
  output logic                         in_ready,
  input  logic        [VALUE_BITS-1:0] h_mag [2],
  input  logic                         h_neg [2],
  input  logic signed [VALUE_BITS-1:0] x_scale,
  input  logic signed [VALUE_BITS-1:0] y_scale,
  input  logic                         enable,
  tvbm_result_if.source                result
);

  localparam int W  = VALUE_BITS;
  localparam int F  = FRACTION_BITS;
  localparam int HW = (W + 1) / 2;
  localparam int LW = W - HW;
  localparam int PW = 2 * W;
  localparam int RW = 2 * W + 1 - F;
  localparam logic [PW:0]   RND     = {{PW{1'b0}}, 1'b1} << (F - 1);
  localparam logic [RW-1:0] LIM_POS = {{(RW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [RW-1:0] LIM_NEG = LIM_POS + 1'b1;

  function automatic logic [W-1:0] mag(input logic signed [W-1:0] a);
    logic [W-1:0] u;
    u = a;
    return a[W-1] ? (~u + 1'b1) : u;
  endfunction

  logic              v5, v6;
  logic              en5, en6, en7;
  logic              sat5, lim5, sat6, lim6;
  logic [W-1:0]      s_mag [2];
  logic              s_neg [2];
  logic              neg5 [2];
  logic              neg6 [2];
  logic [2*HW-1:0]   pll5 [2];
  logic [W-1:0]      plh5 [2];
  logic [W-1:0]      phl5 [2];
  logic [2*LW-1:0]   phh5 [2];
  logic [PW:0]       acc [2];
  logic [RW-1:0]     r6 [2];
  logic [RW-1:0]     limit [2];
  logic              over [2];
  logic [W-1:0]      clip [2];
  logic [W-1:0]      coeff [2];
  logic              take;

  assign en7      = !result.valid || result.ready;
  assign en6      = !v6 || en7;
  assign en5      = !v5 || en6;
  assign in_ready = en5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5           <= 1'b0;
      v6           <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (en5) v5 <= lctl.valid;
      if (en6) v6 <= v5;
      if (en7) result.valid <= v6;
    end
  end

  // scale magnitudes follow the registers; the user must change them only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    s_mag[0] <= mag(x_scale);
    s_mag[1] <= mag(y_scale);
    s_neg[0] <= x_scale[W-1];
    s_neg[1] <= y_scale[W-1];
  end

  // four half-width partial products per direction
  always_ff @(posedge clk) begin
    if (en5) begin
      sat5 <= lctl.sat;
      lim5 <= lctl.lim;
      for (int d = 0; d < 2; d++) begin
        neg5[d] <= h_neg[d] ^ s_neg[d];
        pll5[d] <= h_mag[d][HW-1:0] * s_mag[d][HW-1:0];
        plh5[d] <= h_mag[d][HW-1:0] * s_mag[d][W-1:HW];
        phl5[d] <= h_mag[d][W-1:HW] * s_mag[d][HW-1:0];
        phh5[d] <= h_mag[d][W-1:HW] * s_mag[d][W-1:HW];
      end
    end
  end

  // full product plus half an lsb, then drop the fraction
  always_comb begin
    for (int d = 0; d < 2; d++) begin
      acc[d] = ((PW+1)'(phh5[d]) << (2 * HW)) + ((PW+1)'(plh5[d]) << HW) +
               ((PW+1)'(phl5[d]) << HW) + (PW+1)'(pll5[d]) + RND;
    end
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      sat6 <= sat5;
      lim6 <= lim5;
      for (int d = 0; d < 2; d++) begin
        neg6[d] <= neg5[d];
        r6[d]   <= acc[d][PW:F];
      end
    end
  end

  // clip the magnitude, a negative result reaches one further
  always_comb begin
    for (int d = 0; d < 2; d++) begin
      limit[d] = neg6[d] ? LIM_NEG : LIM_POS;
      over[d]  = r6[d] > limit[d];
      clip[d]  = over[d] ? limit[d][W-1:0] : r6[d][W-1:0];
      coeff[d] = neg6[d] ? (~clip[d] + 1'b1) : clip[d];
    end
  end

  assign take = enable & lim6;

  // output register, disabled limiter reports all zero
  always_ff @(posedge clk) begin
    if (en7) begin
      result.limited       <= take;
      result.x_slope_coeff <= take ? coeff[0] : '0;
      result.y_slope_coeff <= take ? coeff[1] : '0;
      result.saturated     <= enable & (sat6 | (lim6 & (over[0] | over[1])));
    end
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// tb: self-checking bench for tvb_minmod_face_slope_limiter over its cell and result channels
// depends on tvbm_pkg, tvbm_if and the limiter rtl; predicts every result from its own model
module tb;
  import tvbm_pkg::*;

  localparam int     VB           = 32;
  localparam longint VMAX         = 64'sd2147483647;
  localparam longint VMIN         = -64'sd2147483648;
  localparam longint ONE          = 64'sd65536;
  localparam int     PIPE_LATENCY = 7;
  localparam int     STUCK_LIMIT  = 5000;
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic signed [VB-1:0] cell_mean;
    logic signed [VB-1:0] left_mean;
    logic signed [VB-1:0] right_mean;
    logic signed [VB-1:0] bottom_mean;
    logic signed [VB-1:0] top_mean;
    logic        [3:0]    neighbour_mask;
    logic signed [VB-1:0] face_left;
    logic signed [VB-1:0] face_right;
    logic signed [VB-1:0] face_bottom;
    logic signed [VB-1:0] face_top;
  } cell_req_t;

  typedef struct packed {
    logic                 limited;
    logic signed [VB-1:0] x_slope_coeff;
    logic signed [VB-1:0] y_slope_coeff;
    logic                 saturated;
  } slope_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                      cfg_wr_en;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [VB-1:0]             cfg_data;

  tvbm_cell_if   #(.VALUE_BITS(VB)) cell_ch ();
  tvbm_result_if #(.VALUE_BITS(VB)) result_ch ();

  tvb_minmod_face_slope_limiter #(
    .VALUE_BITS   (VB),
    .FRACTION_BITS(16)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cell_req (cell_ch),
    .result   (result_ch),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the limiter registers, reset values
  logic                 lim_enable = 1'b1;
  logic [VB-2:0]        lim_tvb    = '0;
  logic [VB-2:0]        lim_change = '0;
  logic signed [VB-1:0] lim_xscale = 32'sd65536;
  logic signed [VB-1:0] lim_yscale = 32'sd65536;

  cell_req_t  pending_cells[$];
  slope_res_t expected_slopes[$];
  cell_req_t  drive_req;
  int         send_gap;
  int         recv_stall;
  int         mismatches;
  int         stuck;
  bit         calm;

  // difference clipped to the value range
  function automatic longint clip_sub(longint a, longint b, inout bit sat);
    longint d;
    d = a - b;
    if (d > VMAX) begin
      sat = 1'b1;
      d = VMAX;
    end else if (d < VMIN) begin
      sat = 1'b1;
      d = VMIN;
    end
    return d;
  endfunction

  // tvb minmod; zero counts as negative
  function automatic longint tvb_minmod(longint a, longint b, longint c);
    longint ma, mb, mc, m;
    bit na, nb, nc;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    mc = (c < 0) ? -c : c;
    na = (a <= 0);
    nb = (b <= 0);
    nc = (c <= 0);
    if (ma < longint'(lim_tvb)) return a;
    if (na != nb || na != nc) return 0;
    m = ma;
    if (mb < m) m = mb;
    if (mc < m) m = mc;
    return na ? -m : m;
  endfunction

  // half slope times basis reciprocal, rounded half away from zero, clipped
  function automatic longint scale_slope(longint h, longint s, inout bit sat);
    bit neg;
    longint p, q, top;
    neg = (h < 0) != (s < 0);
    p = ((h < 0) ? -h : h) * ((s < 0) ? -s : s);
    q = (p + 64'sd32768) >>> 16;
    top = neg ? -VMIN : VMAX;
    if (q > top) begin
      sat = 1'b1;
      q = top;
    end
    return neg ? -q : q;
  endfunction

  // expected result for one cell request under the current registers
  function automatic slope_res_t limit_cell(cell_req_t c);
    slope_res_t r;
    longint mean, db, df, jump_b, jump_f, change;
    longint nbv[4];
    longint fcv[4];
    longint jb[2];
    longint jf[2];
    bit sat;
    bit lim;
    r = '0;
    if (!lim_enable) return r;
    sat = 1'b0;
    change = 0;
    mean = c.cell_mean;
    nbv[0] = c.left_mean;
    nbv[1] = c.right_mean;
    nbv[2] = c.bottom_mean;
    nbv[3] = c.top_mean;
    fcv[0] = c.face_left;
    fcv[1] = c.face_right;
    fcv[2] = c.face_bottom;
    fcv[3] = c.face_top;
    for (int d = 0; d < 2; d++) begin
      db = 0;
      df = 0;
      if (c.neighbour_mask[2*d]) db = clip_sub(mean, nbv[2*d], sat);
      if (c.neighbour_mask[2*d+1]) df = clip_sub(nbv[2*d+1], mean, sat);
      jump_b = clip_sub(mean, fcv[2*d], sat);
      jump_f = clip_sub(fcv[2*d+1], mean, sat);
      jb[d] = tvb_minmod(jump_b, db, df);
      jf[d] = tvb_minmod(jump_f, db, df);
      change += (jb[d] >= jump_b) ? jb[d] - jump_b : jump_b - jb[d];
      change += (jf[d] >= jump_f) ? jf[d] - jump_f : jump_f - jf[d];
    end
    // quarter of the summed change strictly above the threshold
    lim = change > 4 * longint'(lim_change);
    if (lim) begin
      r.x_slope_coeff = 32'(scale_slope((jb[0] + jf[0]) >>> 1, lim_xscale, sat));
      r.y_slope_coeff = 32'(scale_slope((jb[1] + jf[1]) >>> 1, lim_yscale, sat));
    end
    r.limited = lim;
    r.saturated = sat;
    return r;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 65) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic longint rand_mag(int k);
    return longint'($urandom) & ((64'sd1 << k) - 1);
  endfunction

  // magnitude with the given sign, now and then the opposite one
  function automatic longint signed_mag(longint s, int k);
    if ($urandom_range(0, 99) < 15) return -s * rand_mag(k);
    return s * rand_mag(k);
  endfunction

  function automatic longint corner_value();
    case ($urandom_range(0, 5))
      0: return VMIN;
      1: return VMAX;
      2: return 0;
      3: return -1;
      4: return 1;
      default: return longint'($signed($urandom));
    endcase
  endfunction

  function automatic cell_req_t make_cell(longint mean, longint l, longint r, longint b,
                                          longint t, logic [3:0] mask, longint fl,
                                          longint fr, longint fb, longint ft);
    cell_req_t c;
    c.cell_mean      = 32'(mean);
    c.left_mean      = 32'(l);
    c.right_mean     = 32'(r);
    c.bottom_mean    = 32'(b);
    c.top_mean       = 32'(t);
    c.neighbour_mask = mask;
    c.face_left      = 32'(fl);
    c.face_right     = 32'(fr);
    c.face_bottom    = 32'(fb);
    c.face_top       = 32'(ft);
    return c;
  endfunction

  // mostly smooth cells with shared slope signs, some corner values and some raw noise
  function automatic cell_req_t random_cell();
    int pick, k;
    longint mean, sx, sy;
    logic [3:0] mask;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      return make_cell($urandom, $urandom, $urandom, $urandom, $urandom,
                       4'($urandom_range(0, 15)), $urandom, $urandom, $urandom, $urandom);
    end
    if (pick < 30) begin
      return make_cell(corner_value(), corner_value(), corner_value(), corner_value(),
                       corner_value(), 4'($urandom_range(0, 15)), corner_value(),
                       corner_value(), corner_value(), corner_value());
    end
    k = $urandom_range(0, 28);
    mean = longint'($signed($urandom)) >>> $urandom_range(0, 31);
    sx = $urandom_range(0, 1) ? 1 : -1;
    sy = $urandom_range(0, 1) ? 1 : -1;
    mask = ($urandom_range(0, 99) < 75) ? 4'hF : 4'($urandom_range(0, 15));
    return make_cell(mean, mean - signed_mag(sx, k), mean + signed_mag(sx, k),
                     mean - signed_mag(sy, k), mean + signed_mag(sy, k), mask,
                     mean - signed_mag(sx, k), mean + signed_mag(sx, k),
                     mean - signed_mag(sy, k), mean + signed_mag(sy, k));
  endfunction

  // cell request driver
  always @(posedge clk) begin
    if (rst) begin
      cell_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (cell_ch.valid && cell_ch.ready) expected_slopes.push_back(limit_cell(drive_req));
      if (!cell_ch.valid || cell_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          cell_ch.valid <= 1'b0;
        end else if (pending_cells.size() > 0) begin
          drive_req = pending_cells.pop_front();
          cell_ch.cell_mean      <= drive_req.cell_mean;
          cell_ch.left_mean      <= drive_req.left_mean;
          cell_ch.right_mean     <= drive_req.right_mean;
          cell_ch.bottom_mean    <= drive_req.bottom_mean;
          cell_ch.top_mean       <= drive_req.top_mean;
          cell_ch.neighbour_mask <= drive_req.neighbour_mask;
          cell_ch.face_left      <= drive_req.face_left;
          cell_ch.face_right     <= drive_req.face_right;
          cell_ch.face_bottom    <= drive_req.face_bottom;
          cell_ch.face_top       <= drive_req.face_top;
          cell_ch.valid          <= 1'b1;
          send_gap = calm ? 0 : pick_gap();
        end else begin
          cell_ch.valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s differs, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // result monitor with random back-pressure
  always @(posedge clk) begin
    slope_res_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (expected_slopes.size() == 0) begin
          mismatches++;
          $display("%0t: result with none expected, limited %0d x %0d y %0d saturated %0d",
                   $time, result_ch.limited, result_ch.x_slope_coeff,
                   result_ch.y_slope_coeff, result_ch.saturated);
        end else begin
          want = expected_slopes.pop_front();
          check_field("limited", want.limited, result_ch.limited);
          check_field("x_slope_coeff", want.x_slope_coeff, result_ch.x_slope_coeff);
          check_field("y_slope_coeff", want.y_slope_coeff, result_ch.y_slope_coeff);
          check_field("saturated", want.saturated, result_ch.saturated);
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
        recv_stall = calm ? 0 : pick_gap();
      end
    end
  end

  // watchdog: cycles with work outstanding but no request moving on either side
  always @(posedge clk) begin
    if (rst || (cell_ch.valid && cell_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (pending_cells.size() == 0 && expected_slopes.size() == 0 && !cell_ch.valid)) begin
      stuck <= 0;
    end else if (stuck >= STUCK_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [VB-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_LIMITER_ENABLE:   lim_enable = data[0];
      REG_TVB_THRESHOLD:    lim_tvb    = data[VB-2:0];
      REG_CHANGE_THRESHOLD: lim_change = data[VB-2:0];
      REG_X_BASIS_SCALE:    lim_xscale = data;
      REG_Y_BASIS_SCALE:    lim_yscale = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // wait for the pipeline to drain
  task automatic wait_idle();
    while (pending_cells.size() != 0 || cell_ch.valid || expected_slopes.size() != 0)
      @(posedge clk);
    repeat (PIPE_LATENCY + 3) @(posedge clk);
  endtask

  task automatic set_limiter(logic en, logic [VB-1:0] tvb, logic [VB-1:0] chg,
                             logic [VB-1:0] xs, logic [VB-1:0] ys, bit no_idle);
    wait_idle();
    write_reg(REG_LIMITER_ENABLE, {31'($urandom), en});
    write_reg(REG_TVB_THRESHOLD, tvb);
    write_reg(REG_CHANGE_THRESHOLD, chg);
    write_reg(REG_X_BASIS_SCALE, xs);
    write_reg(REG_Y_BASIS_SCALE, ys);
    cfg_wr_en <= 1'b0;
    calm = no_idle;
  endtask

  task automatic push_random(int n);
    for (int i = 0; i < n; i++) pending_cells.push_back(random_cell());
  endtask

  // stimulus sequence
  initial begin
    logic [VB-1:0] tvb, chg, xs, ys;
    mismatches = 0;
    calm = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cell_ch.valid = 1'b0;
    cell_ch.cell_mean = '0;
    cell_ch.left_mean = '0;
    cell_ch.right_mean = '0;
    cell_ch.bottom_mean = '0;
    cell_ch.top_mean = '0;
    cell_ch.neighbour_mask = '0;
    cell_ch.face_left = '0;
    cell_ch.face_right = '0;
    cell_ch.face_bottom = '0;
    cell_ch.face_top = '0;
    result_ch.ready = 1'b0;
    rst = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed cells under the reset register values
    pending_cells.push_back(make_cell(0, 0, 0, 0, 0, 4'hF, 0, 0, 0, 0));
    pending_cells.push_back(make_cell(0, 0, 0, 0, 0, 4'h0, 0, 0, 0, 0));
    // smooth cell, jumps kept
    pending_cells.push_back(make_cell(0, -ONE, ONE, -2*ONE, 2*ONE, 4'hF,
                                      -ONE/2, ONE/2, -ONE, ONE));
    // local extremum, slopes flattened
    pending_cells.push_back(make_cell(0, ONE, ONE, ONE, ONE, 4'hF,
                                      ONE/4, -ONE/4, ONE/4, -ONE/4));
    // equal neighbour gives a zero difference, which counts as negative
    pending_cells.push_back(make_cell(ONE, ONE, 2*ONE, ONE, 2*ONE, 4'hF,
                                      ONE/2, 3*ONE/2, ONE/2, 3*ONE/2));
    // no neighbours present, negative jumps
    pending_cells.push_back(make_cell(ONE, 0, 0, 0, 0, 4'h0, 2*ONE, 0, 2*ONE, 0));
    // equal magnitudes everywhere
    pending_cells.push_back(make_cell(0, -ONE, ONE, -ONE, ONE, 4'hF, -ONE, ONE, -ONE, ONE));
    // steep jumps reduced to the neighbour differences, one mask bit at a time too
    pending_cells.push_back(make_cell(0, -ONE, 2*ONE, -ONE, 2*ONE, 4'hF,
                                      -3*ONE, 3*ONE, -3*ONE, 3*ONE));
    for (int b = 0; b < 4; b++)
      pending_cells.push_back(make_cell(0, -ONE, 2*ONE, -ONE, 2*ONE, 4'(1 << b),
                                        -3*ONE, 3*ONE, -3*ONE, 3*ONE));
    // clipped differences at the range ends
    pending_cells.push_back(make_cell(VMAX, VMIN, VMIN, VMIN, VMAX, 4'hF,
                                      VMIN, VMIN, VMAX, VMIN));
    pending_cells.push_back(make_cell(VMIN, VMAX, VMAX, VMAX, VMAX, 4'hF,
                                      VMAX, VMAX, VMAX, VMAX));
    pending_cells.push_back(make_cell(VMAX, VMAX, VMAX, VMAX, VMAX, 4'hF,
                                      VMAX, VMAX, VMAX, VMAX));
    pending_cells.push_back(make_cell(VMIN, VMIN, VMIN, VMIN, VMIN, 4'hF,
                                      VMIN, VMIN, VMIN, VMIN));
    pending_cells.push_back(make_cell(VMAX, 0, 0, 0, 0, 4'hF, 0, 0, 0, 0));
    pending_cells.push_back(make_cell(-1, 1, 1, 1, 1, 4'hF, 1, 1, 1, 1));
    push_random(150);

    // limiter off
    set_limiter(1'b0, $urandom, $urandom, $urandom, $urandom, 1'b0);
    push_random(100);

    // half-unit scales, rounding of halves, no idling
    set_limiter(1'b1, 32'd0, 32'd0, 32'h0000_8000, 32'hFFFF_8000, 1'b1);
    pending_cells.push_back(make_cell(0, -2, 2, 2, -2, 4'hF, -1, 5, 1, -5));
    pending_cells.push_back(make_cell(0, -2, 2, 2, -2, 4'hF, 1, -5, -1, 5));
    push_random(150);

    // widest tvb threshold
    set_limiter(1'b1, 32'hFFFF_FFFF, 32'd0, 32'h0001_0000, 32'h0001_0000, 1'b0);
    push_random(100);

    // widest change threshold
    set_limiter(1'b1, 32'($urandom_range(0, 1 << 20)), 32'hFFFF_FFFF,
                32'h0001_0000, 32'h0001_0000, 1'b0);
    push_random(100);

    // extreme scales, plus a write to an unused index
    set_limiter(1'b1, 32'd0, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    write_reg(REG_UNUSED, $urandom);
    cfg_wr_en <= 1'b0;
    push_random(150);

    // zero scales
    set_limiter(1'b1, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
    push_random(100);

    // random register settings
    for (int p = 0; p < 7; p++) begin
      tvb = $urandom >> $urandom_range(0, 31);
      chg = $urandom >> $urandom_range(4, 31);
      xs  = $urandom_range(0, 1) ? $urandom : 32'(ONE + signed_mag(1, 16));
      ys  = $urandom_range(0, 1) ? $urandom : 32'(ONE + signed_mag(-1, 16));
      set_limiter(1'b1, tvb, chg, xs, ys, p == 3);
      push_random(100);
    end

    // drain and report
    while (pending_cells.size() != 0 || cell_ch.valid || expected_slopes.size() != 0)
      @(posedge clk);
    repeat (PIPE_LATENCY * 3) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tvbm_pkg.sv
rtl/tvbm_if.sv
rtl/tvbm_diff.sv
rtl/tvbm_jump.sv
rtl/tvbm_coeff.sv
rtl/tvb_minmod_face_slope_limiter.sv
dv/tb.sv
